FILE: rtl/tpg_pkg.sv
// Shared types and constants for the touch/pinch gesture tracker.
// Depends on nothing; used by every module in rtl/ except tpg_queue.
package tpg_pkg;

  localparam logic [1:0] DOWN_CODE = 2'd2;

  typedef enum logic [2:0] {
    EV_TOUCH_DOWN = 3'd0,
    EV_TOUCH_DRAG = 3'd1,
    EV_TOUCH_UP   = 3'd2,
    EV_PINCH_DOWN = 3'd3,
    EV_PINCH_DRAG = 3'd4,
    EV_PINCH_UP   = 3'd5
  } tpg_kind_t;

  // control part of one queued sample: one or two events
  typedef struct packed {
    tpg_kind_t kind_a;
    tpg_kind_t kind_b;
    logic      two_ev;
  } tpg_ctl_t;

endpackage

FILE: rtl/touch_pinch_gesture_tracker_top.sv
// Top level of the touch/pinch gesture tracker.
// Depends on tpg_pkg, tpg_front, tpg_queue and tpg_back.
//
// Input channel (in_*): one controller sample per word, two event codes and
// two raw points. A code of 2 marks a contact as down. in_stall rises only
// while the two-entry queue between front and back end is full.
// Result channel (out_*): one gesture event per word (touch down/drag/up,
// pinch down/drag/up) with the stored points after the update; the first
// word of a two-word sample keeps the old first point. out_last marks the
// final event of a sample. A sample gives zero, one or two words.
// A sample with events is queued; its first event then goes into the
// back end's single output register when the result side is free.
// Throughput: one sample per cycle for samples with at most one event
// while out_stall is low; a release of pinch and touch gives two words.
// Reset (synchronous, rst_n low) clears the flags, stored points and queue.
// While out_stall is high the current word holds; the queue absorbs up to
// two more samples before in_stall is raised.
module touch_pinch_gesture_tracker_top #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_touch1_event,
  input  logic [1:0]            in_touch2_event,
  input  logic [COORD_BITS-1:0] in_touch1_x,
  input  logic [COORD_BITS-1:0] in_touch1_y,
  input  logic [COORD_BITS-1:0] in_touch2_x,
  input  logic [COORD_BITS-1:0] in_touch2_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_event_kind,
  output logic [COORD_BITS-1:0] out_first_x,
  output logic [COORD_BITS-1:0] out_first_y,
  output logic [COORD_BITS-1:0] out_second_x,
  output logic [COORD_BITS-1:0] out_second_y,
  output logic                  out_last
);

  localparam int CTL_W = $bits(tpg_pkg::tpg_ctl_t);
  localparam int QW    = CTL_W + 6 * COORD_BITS;

  logic                  accept, push, pop, q_empty, q_full;
  tpg_pkg::tpg_ctl_t     push_ctl, head_ctl;
  logic [COORD_BITS-1:0] p_ax, p_ay, p_fx, p_fy, p_sx, p_sy;
  logic [COORD_BITS-1:0] h_ax, h_ay, h_fx, h_fy, h_sx, h_sy;
  logic [QW-1:0]         push_word, head_word;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  tpg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .touch1_event (in_touch1_event),
    .touch2_event (in_touch2_event),
    .touch1_x     (in_touch1_x),
    .touch1_y     (in_touch1_y),
    .touch2_x     (in_touch2_x),
    .touch2_y     (in_touch2_y),
    .push         (push),
    .push_ctl     (push_ctl),
    .a_first_x    (p_ax),
    .a_first_y    (p_ay),
    .first_x      (p_fx),
    .first_y      (p_fy),
    .second_x     (p_sx),
    .second_y     (p_sy)
  );

  assign push_word = {push_ctl, p_ax, p_ay, p_fx, p_fy, p_sx, p_sy};

  tpg_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_word),
    .pop       (pop),
    .head      (head_word),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign {head_ctl, h_ax, h_ay, h_fx, h_fy, h_sx, h_sy} = head_word;

  tpg_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_ctl          (head_ctl),
    .q_a_first_x    (h_ax),
    .q_a_first_y    (h_ay),
    .q_first_x      (h_fx),
    .q_first_y      (h_fy),
    .q_second_x     (h_sx),
    .q_second_y     (h_sy),
    .q_pop          (pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_event_kind (out_event_kind),
    .out_first_x    (out_first_x),
    .out_first_y    (out_first_y),
    .out_second_x   (out_second_x),
    .out_second_y   (out_second_y),
    .out_last       (out_last)
  );

endmodule

FILE: rtl/tpg_front.sv
// Front end: accepts samples, keeps the gesture flags and stored points,
// and classifies each sample into zero, one or two events. Uses tpg_pkg.
module tpg_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [1:0]            touch1_event,
  input  logic [1:0]            touch2_event,
  input  logic [COORD_BITS-1:0] touch1_x,
  input  logic [COORD_BITS-1:0] touch1_y,
  input  logic [COORD_BITS-1:0] touch2_x,
  input  logic [COORD_BITS-1:0] touch2_y,
  output logic                  push,
  output tpg_pkg::tpg_ctl_t     push_ctl,
  output logic [COORD_BITS-1:0] a_first_x,
  output logic [COORD_BITS-1:0] a_first_y,
  output logic [COORD_BITS-1:0] first_x,
  output logic [COORD_BITS-1:0] first_y,
  output logic [COORD_BITS-1:0] second_x,
  output logic [COORD_BITS-1:0] second_y
);

  logic                  touched_r, touched_nxt;
  logic                  pinched_r, pinched_nxt;
  logic [COORD_BITS-1:0] fx_r, fx_nxt, fy_r, fy_nxt;
  logic [COORD_BITS-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic                  down1, down2, ev;
  logic                  first_diff, second_diff;
  tpg_pkg::tpg_ctl_t     ctl;

  assign down1       = (touch1_event == tpg_pkg::DOWN_CODE);
  assign down2       = (touch2_event == tpg_pkg::DOWN_CODE);
  assign first_diff  = (touch1_x != fx_r) || (touch1_y != fy_r);
  assign second_diff = (touch2_x != sx_r) || (touch2_y != sy_r);

  always_comb begin
    touched_nxt = touched_r;
    pinched_nxt = pinched_r;
    fx_nxt      = fx_r;
    fy_nxt      = fy_r;
    sx_nxt      = sx_r;
    sy_nxt      = sy_r;
    ev          = 1'b0;
    ctl.kind_a  = tpg_pkg::EV_TOUCH_DOWN;
    ctl.kind_b  = tpg_pkg::EV_TOUCH_UP;
    ctl.two_ev  = 1'b0;
    if (down1 && down2) begin
      if (!pinched_r || first_diff || second_diff) begin
        ev          = 1'b1;
        pinched_nxt = 1'b1;
        fx_nxt      = touch1_x;
        fy_nxt      = touch1_y;
        sx_nxt      = touch2_x;
        sy_nxt      = touch2_y;
        ctl.kind_a  = pinched_r ? tpg_pkg::EV_PINCH_DRAG : tpg_pkg::EV_PINCH_DOWN;
      end
    end else if (down1) begin
      if (pinched_r) begin
        ev          = 1'b1;
        pinched_nxt = 1'b0;
        sx_nxt      = touch2_x;
        sy_nxt      = touch2_y;
        ctl.kind_a  = tpg_pkg::EV_PINCH_UP;
      end else if (!touched_r || first_diff) begin
        ev          = 1'b1;
        touched_nxt = 1'b1;
        fx_nxt      = touch1_x;
        fy_nxt      = touch1_y;
        ctl.kind_a  = touched_r ? tpg_pkg::EV_TOUCH_DRAG : tpg_pkg::EV_TOUCH_DOWN;
      end
    end else begin
      // release: pinch up goes first when both flags are set
      if (pinched_r) begin
        ev          = 1'b1;
        pinched_nxt = 1'b0;
        sx_nxt      = touch2_x;
        sy_nxt      = touch2_y;
        ctl.kind_a  = tpg_pkg::EV_PINCH_UP;
      end
      if (touched_r) begin
        ev          = 1'b1;
        touched_nxt = 1'b0;
        fx_nxt      = touch1_x;
        fy_nxt      = touch1_y;
        if (pinched_r) begin
          ctl.two_ev = 1'b1;
          ctl.kind_b = tpg_pkg::EV_TOUCH_UP;
        end else begin
          ctl.kind_a = tpg_pkg::EV_TOUCH_UP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touched_r <= 1'b0;
      pinched_r <= 1'b0;
      fx_r      <= '0;
      fy_r      <= '0;
      sx_r      <= '0;
      sy_r      <= '0;
    end else if (accept) begin
      touched_r <= touched_nxt;
      pinched_r <= pinched_nxt;
      fx_r      <= fx_nxt;
      fy_r      <= fy_nxt;
      sx_r      <= sx_nxt;
      sy_r      <= sy_nxt;
    end
  end

  assign push      = accept && ev;
  assign push_ctl  = ctl;
  // first event of a pair still shows the old first point
  assign a_first_x = ctl.two_ev ? fx_r : fx_nxt;
  assign a_first_y = ctl.two_ev ? fy_r : fy_nxt;
  assign first_x   = fx_nxt;
  assign first_y   = fy_nxt;
  assign second_x  = sx_nxt;
  assign second_y  = sy_nxt;

endmodule

FILE: rtl/tpg_queue.sv
// Two-entry queue between the front and back ends.
// Depends on nothing; word width set by the instantiating module.
module tpg_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         empty,
  output logic         full
);

  logic [W-1:0] entry_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  assign head  = entry_r[rd_ptr_r];
  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);

endmodule

FILE: rtl/tpg_back.sv
// Back end: drains queued samples into the output register, one event per
// cycle unless stalled; a two-event sample gives two words. Uses tpg_pkg.
module tpg_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  tpg_pkg::tpg_ctl_t     q_ctl,
  input  logic [COORD_BITS-1:0] q_a_first_x,
  input  logic [COORD_BITS-1:0] q_a_first_y,
  input  logic [COORD_BITS-1:0] q_first_x,
  input  logic [COORD_BITS-1:0] q_first_y,
  input  logic [COORD_BITS-1:0] q_second_x,
  input  logic [COORD_BITS-1:0] q_second_y,
  output logic                  q_pop,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [2:0]            out_event_kind,
  output logic [COORD_BITS-1:0] out_first_x,
  output logic [COORD_BITS-1:0] out_first_y,
  output logic [COORD_BITS-1:0] out_second_x,
  output logic [COORD_BITS-1:0] out_second_y,
  output logic                  out_last
);

  logic                  valid_r;
  logic                  phase_r;   // second event of head pending
  logic                  load, second;
  tpg_pkg::tpg_kind_t    kind_r;
  logic [COORD_BITS-1:0] fx_r, fy_r, sx_r, sy_r;
  logic                  last_r;

  assign load   = !q_empty && (!valid_r || !out_stall);
  assign second = phase_r;
  assign q_pop  = load && (second || !q_ctl.two_ev);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        phase_r <= q_ctl.two_ev && !second;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= second ? q_ctl.kind_b : q_ctl.kind_a;
      fx_r   <= second ? q_first_x : q_a_first_x;
      fy_r   <= second ? q_first_y : q_a_first_y;
      sx_r   <= q_second_x;
      sy_r   <= q_second_y;
      last_r <= second || !q_ctl.two_ev;
    end
  end

  assign out_valid      = valid_r;
  assign out_event_kind = kind_r;
  assign out_first_x    = fx_r;
  assign out_first_y    = fy_r;
  assign out_second_x   = sx_r;
  assign out_second_y   = sy_r;
  assign out_last       = last_r;

endmodule

FILE: rtl/tpg_checker.sv
// Port-level checks for the gesture tracker, bound to the top level.
// Depends on tpg_pkg and touch_pinch_gesture_tracker_top.
module tpg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_event_kind,
  input logic       out_last
);

  // output register comes up empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_kind) && $stable(out_last))
    else $error("stalled word changed");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_kind <= tpg_pkg::EV_PINCH_UP)
    else $error("event code out of range");

  // only a pinch release can be followed by another word of the same sample
  a_not_last_pinch_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_event_kind == tpg_pkg::EV_PINCH_UP)
    else $error("non-last word is not pinch up");

  a_pair_touch_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last && !out_stall |=>
      out_valid && out_last && out_event_kind == tpg_pkg::EV_TOUCH_UP)
    else $error("pinch up not followed by touch up");

endmodule

bind touch_pinch_gesture_tracker_top tpg_checker u_tpg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_event_kind (out_event_kind),
  .out_last       (out_last)
);
